FILE: src/lcpc_pkg.sv
// Package with payload types and fixed-point constants of the local contrast pixel combiner.
`timescale 1ns / 1ps

package lcpc_pkg;

	localparam int PIX_BITS = 16;
	localparam int NUM_CH   = 3;
	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	// Luma weights, Q0.16, sum 1.0
	localparam logic [15:0] W_BLUE  = 16'd7471;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_RED   = 16'd19595;

	localparam logic [16:0] ONE_Q16   = 17'd65536;
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	// Edge threshold 0.18 in pixel units
	localparam longint EDGE_THR_Q16 = 11796;
	localparam longint EDGE_THR     = ((EDGE_THR_Q16 << PIX_BITS) + 32768) >> 16;
	localparam int     THR_BITS     = $clog2(EDGE_THR);
	localparam int     NUM_BITS     = THR_BITS + 16;

	// Reciprocal of the threshold for the t_edge quotient
	localparam int     RECIP_SHIFT = 44;
	localparam longint EDGE_RECIP  = (64'sd1 <<< RECIP_SHIFT) / EDGE_THR;
	localparam int     RECIP_BITS  = 31;

	// Pipeline depth from accept to result strobe
	localparam int LATENCY = 12;

	typedef struct packed {
		logic [PIX_BITS-1:0] orig_blue;
		logic [PIX_BITS-1:0] orig_green;
		logic [PIX_BITS-1:0] orig_red;
		logic [PIX_BITS-1:0] blur_blue;
		logic [PIX_BITS-1:0] blur_green;
		logic [PIX_BITS-1:0] blur_red;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] out_blue;
		logic [PIX_BITS-1:0] out_green;
		logic [PIX_BITS-1:0] out_red;
	} pix_out_t;

	// Per-pixel data that rides along the pipeline, index is the channel
	typedef struct packed {
		logic [NUM_CH-1:0][PIX_BITS-1:0] orig;
		logic [NUM_CH-1:0][PIX_BITS:0]   diff;
	} carry_t;

endpackage

FILE: src/local_contrast_pixel_combine_top.sv
// Local contrast pixel combiner: twelve-stage pipeline, one pixel per clock.
//
// Usage:
//   Input beat: pixel (original and blurred BGR, Q0.16) is taken at a rising
//   edge where start is high and busy is low. busy stays low: the pipeline
//   advances every cycle and takes a new pixel at every clock.
//   Output beat: result is valid for exactly one cycle while result_valid is
//   high; it is driven by the stage 12 output register at the end of the pipeline.
//   Results leave in input order.
//   Throughput is one pixel per clock; latency is set by the chain of
//   dependent multiplies (luma, threshold reciprocal and its correction,
//   smoothstep, protect times mask, gain, and the split 17x32 detail product).
//   Configuration: cfg_wdata is written to clarity_gain (signed Q2.14) at an
//   edge where cfg_we is high; write it only while no pixel is in flight.
//   Reset (arst_n low) clears all valid bits and sets the gain to zero;
//   pixels in flight are dropped. The receiver cannot stall: it must take
//   each result in the cycle it is shown.
`timescale 1ns / 1ps

module local_contrast_pixel_combine_top
	import lcpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pix_in_t              pixel,
	output logic                 result_valid,
	output pix_out_t             result,
	input  logic                 cfg_we,
	input  logic signed [15:0]   cfg_wdata
);

	logic signed [15:0] gain_q;

	logic [LATENCY:1] vld_s;
	carry_t           carry_s [1:LATENCY-1];

	logic signed [33:0]         dsum_s2;
	logic [31:0]                lsum_s2;
	logic [THR_BITS-1:0]        mag_s3;
	logic                       sat_s3;
	logic [16:0]                tla_s3;
	logic [NUM_BITS-1:0]        num_s4;
	logic [15:0]                q0_s4;
	logic                       sat_s4;
	logic [16:0]                tl2_s4;
	logic [16:0]                t_s5;
	logic [16:0]                mask_s5;
	logic [16:0]                t2_s6;
	logic [17:0]                k_s6;
	logic [16:0]                mask_s6;
	logic [16:0]                protect_s7;
	logic [16:0]                mask_s7;
	logic [16:0]                pm_s8;
	logic signed [31:0]         str_s9;
	logic signed [32:0]         phi_s10 [NUM_CH];
	logic signed [33:0]         plo_s10 [NUM_CH];
	logic signed [47:0]         v_s11   [NUM_CH];
	pix_out_t                   out_s12;

	assign busy = 1'b0;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LATENCY-1:1], start & ~busy};
		end
	end

	// Stage 1: capture original pixel and detail diff; advance the carry
	always_ff @(posedge clk) begin
		carry_s[1].orig[CH_BLUE]  <= pixel.orig_blue;
		carry_s[1].orig[CH_GREEN] <= pixel.orig_green;
		carry_s[1].orig[CH_RED]   <= pixel.orig_red;
		carry_s[1].diff[CH_BLUE]  <= {1'b0, pixel.orig_blue}  - {1'b0, pixel.blur_blue};
		carry_s[1].diff[CH_GREEN] <= {1'b0, pixel.orig_green} - {1'b0, pixel.blur_green};
		carry_s[1].diff[CH_RED]   <= {1'b0, pixel.orig_red}   - {1'b0, pixel.blur_red};
		for (int i = 2; i < LATENCY; i++) begin
			carry_s[i] <= carry_s[i-1];
		end
	end

	// Stage 2: luma of diff and of original
	logic signed [33:0] dx_c [NUM_CH];
	logic signed [33:0] dsum_c;
	logic [33:0]        lsum_c;
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			dx_c[i] = $signed({{17{carry_s[1].diff[i][PIX_BITS]}}, carry_s[1].diff[i]});
		end
		dsum_c = dx_c[CH_BLUE]  * $signed({18'd0, W_BLUE})
			+ dx_c[CH_GREEN] * $signed({18'd0, W_GREEN})
			+ dx_c[CH_RED]   * $signed({18'd0, W_RED});
		lsum_c = {18'd0, carry_s[1].orig[CH_BLUE]}  * {18'd0, W_BLUE}
			+ {18'd0, carry_s[1].orig[CH_GREEN]} * {18'd0, W_GREEN}
			+ {18'd0, carry_s[1].orig[CH_RED]}   * {18'd0, W_RED};
	end

	always_ff @(posedge clk) begin
		dsum_s2 <= dsum_c;
		lsum_s2 <= lsum_c[31:0];
	end

	// Stage 3: round both lumas, edge magnitude and midtone distance
	logic signed [33:0] dround_c;
	logic signed [17:0] dl_c;
	logic [17:0]        dmag_c;
	logic [32:0]        lround_c;
	logic [15:0]        lum_c;
	logic [16:0]        tla_c;
	always_comb begin
		// halves away from zero: add half, less one when negative
		dround_c = dsum_s2 + 34'sd32768 - $signed({33'd0, dsum_s2[33]});
		dl_c     = dround_c[33:16];
		dmag_c   = dl_c[17] ? (~dl_c + 18'sd1) : dl_c;
		lround_c = {1'b0, lsum_s2} + 33'd32768;
		lum_c    = lround_c[31:16];
		if (lum_c[15]) begin
			tla_c = {lum_c, 1'b0} - ONE_Q16;
		end else begin
			tla_c = ONE_Q16 - {lum_c, 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		mag_s3 <= dmag_c[THR_BITS-1:0];
		sat_s3 <= (dmag_c >= 18'(EDGE_THR));
		tla_s3 <= tla_c;
	end

	// Stage 4: estimated quotient by reciprocal; square of midtone distance
	logic [NUM_BITS-1:0]                num_c;
	logic [NUM_BITS+RECIP_BITS-1:0]     qprod_c;
	logic [33:0]                        tsq_c;
	always_comb begin
		num_c   = {mag_s3, 16'd0} + NUM_BITS'(EDGE_THR / 2);
		qprod_c = {{RECIP_BITS{1'b0}}, num_c}
			* {{NUM_BITS{1'b0}}, RECIP_BITS'(EDGE_RECIP)};
		tsq_c   = {17'd0, tla_s3} * {17'd0, tla_s3} + 34'd32768;
	end

	always_ff @(posedge clk) begin
		num_s4 <= num_c;
		q0_s4  <= qprod_c[RECIP_SHIFT+15:RECIP_SHIFT];
		sat_s4 <= sat_s3;
		tl2_s4 <= tsq_c[32:16];
	end

	// Stage 5: correct the quotient by one, cap t; midtone mask
	logic [NUM_BITS-1:0] rem_c;
	logic [NUM_BITS-1:0] qt_c;
	logic [16:0]         t_c;
	always_comb begin
		qt_c  = NUM_BITS'(q0_s4) * NUM_BITS'(EDGE_THR);
		rem_c = num_s4 - qt_c;
		if (sat_s4) begin
			t_c = ONE_Q16;
		end else if (rem_c >= NUM_BITS'(EDGE_THR)) begin
			t_c = {1'b0, q0_s4} + 17'd1;
		end else begin
			t_c = {1'b0, q0_s4};
		end
	end

	always_ff @(posedge clk) begin
		t_s5    <= t_c;
		mask_s5 <= ONE_Q16 - tl2_s4;
	end

	// Stage 6: t squared and 3 - 2t
	logic [33:0] t2_c;
	always_comb begin
		t2_c = {17'd0, t_s5} * {17'd0, t_s5} + 34'd32768;
	end

	always_ff @(posedge clk) begin
		t2_s6   <= t2_c[32:16];
		k_s6    <= THREE_Q16 - {t_s5, 1'b0};
		mask_s6 <= mask_s5;
	end

	// Stage 7: smoothstep and protect factor
	logic [35:0] s_c;
	logic [19:0] sv_c;
	always_comb begin
		s_c  = {19'd0, t2_s6} * {18'd0, k_s6} + 36'd32768;
		sv_c = s_c[35:16];
	end

	always_ff @(posedge clk) begin
		protect_s7 <= (sv_c >= 20'(ONE_Q16)) ? 17'd0 : (ONE_Q16 - sv_c[16:0]);
		mask_s7    <= mask_s6;
	end

	// Stage 8: protect times mask
	logic [33:0] pm_c;
	always_comb begin
		pm_c = {17'd0, protect_s7} * {17'd0, mask_s7} + 34'd32768;
	end

	always_ff @(posedge clk) begin
		pm_s8 <= pm_c[32:16];
	end

	// Stage 9: strength in Q2.30
	logic signed [33:0] str_c;
	always_comb begin
		str_c = $signed({{18{gain_q[15]}}, gain_q}) * $signed({17'd0, pm_s8});
	end

	always_ff @(posedge clk) begin
		str_s9 <= str_c[31:0];
	end

	// Stage 10: detail times strength as two partial products
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			phi_s10[i] <= $signed({{16{carry_s[9].diff[i][PIX_BITS]}}, carry_s[9].diff[i]})
				* $signed({{17{str_s9[31]}}, str_s9[31:16]});
			plo_s10[i] <= $signed({{17{carry_s[9].diff[i][PIX_BITS]}}, carry_s[9].diff[i]})
				* $signed({18'd0, str_s9[15:0]});
		end
	end

	// Stage 11: combine partial products
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			v_s11[i] <= ($signed({{15{phi_s10[i][32]}}, phi_s10[i]}) <<< 16)
				+ $signed({{14{plo_s10[i][33]}}, plo_s10[i]});
		end
	end

	// Stage 12: round delta, add to original, saturate
	logic signed [47:0]        vr_c  [NUM_CH];
	logic signed [18:0]        sum_c [NUM_CH];
	logic [NUM_CH-1:0][PIX_BITS-1:0] pix_c;
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			vr_c[i]  = v_s11[i] + 48'sd536870912 - $signed({47'd0, v_s11[i][47]});
			sum_c[i] = $signed({3'd0, carry_s[11].orig[i]})
				+ $signed({vr_c[i][47], vr_c[i][47:30]});
			if (sum_c[i] < 19'sd0) begin
				pix_c[i] = '0;
			end else if (sum_c[i] > $signed({3'd0, {PIX_BITS{1'b1}}})) begin
				pix_c[i] = '1;
			end else begin
				pix_c[i] = sum_c[i][PIX_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		out_s12.out_blue  <= pix_c[CH_BLUE];
		out_s12.out_green <= pix_c[CH_GREEN];
		out_s12.out_red   <= pix_c[CH_RED];
	end

	assign result_valid = vld_s[LATENCY];
	assign result       = out_s12;

	// Every result traces back to an accepted beat
	a_result_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start & ~busy, LATENCY))
		else $error("result strobe without matching accepted beat");

	// Every accepted beat produces a result
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start & ~busy) |-> ##LATENCY result_valid)
		else $error("accepted beat produced no result");

	// Corrected edge ratio never passes 1.0
	a_t_capped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] |-> (t_s5 <= ONE_Q16))
		else $error("edge ratio above 1.0");

	// Combined protect and mask stay within 1.0
	a_pm_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[8] |-> (pm_s8 <= ONE_Q16))
		else $error("protect times mask above 1.0");

endmodule
